// ----- src/hysteresis_line_crossing_counter_core_defines.svh -----
// assertion macros for the hysteresis line-crossing counter
// used by the port checker; no other dependencies
`ifndef HYSTERESIS_LINE_CROSSING_COUNTER_CORE_DEFINES_SVH
`define HYSTERESIS_LINE_CROSSING_COUNTER_CORE_DEFINES_SVH

// concurrent assertion on a given clock, held off while reset is low
`define HLCC_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// same, on the block's own clock and reset names
`define HLCC_CHECK(lbl, prop, msg) `HLCC_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ----- src/hlcc_pkg.sv -----
// shared constants, register codes and item types of the line-crossing counter
// no dependencies
`default_nettype none

package hlcc_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int BASE_BITS   = 10;
	localparam int BAND_BITS   = 8;
	localparam int RUN_BITS    = 7;
	localparam int LINE_BITS   = 4;
	localparam int ZONE_BITS   = 2;

	// compare width: wide enough for sample plus band and base plus band
	localparam int CMP_BITS = ((SAMPLE_BITS > BASE_BITS) ? SAMPLE_BITS : BASE_BITS) + 1;

	localparam int REG_COUNT     = 3;
	localparam int ADDR_BITS     = $clog2(REG_COUNT * 4);
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = ADDR_BITS - 2;

	localparam logic [REG_IDX_BITS-1:0] REG_BASE_LEVEL = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_BAND       = REG_IDX_BITS'(1);
	localparam logic [REG_IDX_BITS-1:0] REG_SETTLE     = REG_IDX_BITS'(2);

	localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_BITS'(468);
	localparam logic [BAND_BITS-1:0] BAND_RESET   = BAND_BITS'(50);
	localparam logic [RUN_BITS-1:0]  SETTLE_RESET = RUN_BITS'(10);
	localparam logic [RUN_BITS-1:0]  RUN_CAP      = RUN_BITS'(100);

	localparam logic [ZONE_BITS-1:0] ZONE_LIGHT     = ZONE_BITS'(0);
	localparam logic [ZONE_BITS-1:0] ZONE_DARK      = ZONE_BITS'(1);
	localparam logic [ZONE_BITS-1:0] ZONE_UNCERTAIN = ZONE_BITS'(2);

	typedef struct packed {
		logic [BASE_BITS-1:0] base_level;
		logic [BAND_BITS-1:0] band;
		logic [RUN_BITS-1:0]  settle_count;
	} cfg_t;

	typedef struct packed {
		logic [RUN_BITS-1:0]  dark_run;
		logic [RUN_BITS-1:0]  light_run;
		logic                 crossing;
		logic [LINE_BITS-1:0] remaining;
	} track_state_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   restart;
		logic [LINE_BITS-1:0]   line_target;
	} in_item_t;

	typedef struct packed {
		logic [ZONE_BITS-1:0] zone;
		logic                 line_crossed;
		logic [LINE_BITS-1:0] lines_left;
		logic                 done_res;
	} out_item_t;

endpackage

`default_nettype wire

// ----- src/hlcc_if.sv -----
// valid/ready channel interfaces for sample items and result items
// depends on hlcc_pkg
`default_nettype none

interface hlcc_in_if;
	import hlcc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   restart;
	logic [LINE_BITS-1:0]   line_target;

	modport source (output valid, sample, restart, line_target, input ready);
	modport sink   (input valid, sample, restart, line_target, output ready);
endinterface

interface hlcc_out_if;
	import hlcc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ZONE_BITS-1:0] zone;
	logic                 line_crossed;
	logic [LINE_BITS-1:0] lines_left;
	logic                 done_res;

	modport source (output valid, zone, line_crossed, lines_left, done_res, input ready);
	modport sink   (input valid, zone, line_crossed, lines_left, done_res, output ready);
endinterface

`default_nettype wire

// ----- src/hysteresis_line_crossing_counter_core.sv -----
// top level of the hysteresis line-crossing counter
// depends on hlcc_pkg, hlcc_if, hlcc_cfg_regs and hlcc_update
//
// usage
//  - in_ch carries one sensor item per handshake: sample, restart, line_target.
//    a restart item clears the dark and light run counters and the crossing flag
//    and loads line_target as the number of lines still to count
//  - out_ch returns exactly one result item per input item, in order:
//    zone, line_crossed, lines_left and done_res
//  - apb port sets base_level (0x0), band (0x4) and settle_count (0x8); write
//    them only while no item is in flight. pready is tied high
//  - latency: an accepted item passes through the input register and then the
//    result register before it is shown on out_ch
//  - throughput: one item per cycle unless out_ch stalls; the run counters,
//    crossing flag and line count live in one register set updated once per
//    item, so back-to-back items see each other's state with no bubble
//  - input register and result register are separate stages: while a result
//    waits for out_ch.ready the block still takes one more item into its input
//    register; in_ch.ready drops only when both stages are full and stalled
//  - reset (arst_n low) empties both stages, clears all tracking state and
//    returns the registers to 468, 50 and 10
`default_nettype none

module hysteresis_line_crossing_counter_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	hlcc_in_if.sink                                 in_ch,
	hlcc_out_if.source                              out_ch,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [hlcc_pkg::ADDR_BITS-1:0]     paddr,
	input  wire logic [hlcc_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [hlcc_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                    pready
);
	import hlcc_pkg::*;

	cfg_t         cfg;
	track_state_t state_q;
	track_state_t state_nxt;
	in_item_t     item_s1;
	logic         valid_s1;
	out_item_t    result_nxt;
	out_item_t    result_s2;
	logic         valid_s2;
	logic         adv_s1;
	in_item_t     in_item;

	// register file
	hlcc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshakes: stage 1 moves on when the result register is free or draining
	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	assign in_item.sample      = in_ch.sample;
	assign in_item.restart     = in_ch.restart;
	assign in_item.line_target = in_ch.line_target;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_item;
		end
	end

	// classification and tracking update for the item in stage 1
	hlcc_update u_update (
		.cfg       (cfg),
		.state_cur (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.result    (result_nxt)
	);

	// tracking state advances once per item, as it leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.zone         = result_s2.zone;
	assign out_ch.line_crossed = result_s2.line_crossed;
	assign out_ch.lines_left   = result_s2.lines_left;
	assign out_ch.done_res     = result_s2.done_res;

endmodule

`default_nettype wire

// ----- src/hlcc_cfg_regs.sv -----
// apb register file: base level, band and settle count
// depends on hlcc_pkg
`default_nettype none

module hlcc_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [hlcc_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [hlcc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [hlcc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                     pready,
	output hlcc_pkg::cfg_t                           cfg
);
	import hlcc_pkg::*;

	logic [BASE_BITS-1:0]    base_level_q;
	logic [BAND_BITS-1:0]    band_q;
	logic [RUN_BITS-1:0]     settle_count_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_level_q   <= BASE_RESET;
			band_q         <= BAND_RESET;
			settle_count_q <= SETTLE_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BASE_LEVEL: base_level_q   <= pwdata[BASE_BITS-1:0];
				REG_BAND:       band_q         <= pwdata[BAND_BITS-1:0];
				REG_SETTLE:     settle_count_q <= pwdata[RUN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_BASE_LEVEL: prdata = APB_DATA_BITS'(base_level_q);
			REG_BAND:       prdata = APB_DATA_BITS'(band_q);
			REG_SETTLE:     prdata = APB_DATA_BITS'(settle_count_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.base_level   = base_level_q;
	assign cfg.band         = band_q;
	assign cfg.settle_count = settle_count_q;

endmodule

`default_nettype wire

// ----- src/hlcc_update.sv -----
// per-item logic: zone classification, run counters, crossing flag, line count
// depends on hlcc_pkg
`default_nettype none

module hlcc_update (
	input  hlcc_pkg::cfg_t         cfg,
	input  hlcc_pkg::track_state_t state_cur,
	input  hlcc_pkg::in_item_t     item,
	output hlcc_pkg::track_state_t state_nxt,
	output hlcc_pkg::out_item_t    result
);
	import hlcc_pkg::*;

	logic [CMP_BITS-1:0] sample_ext;
	logic [CMP_BITS-1:0] base_ext;
	logic [CMP_BITS-1:0] hi_bound;
	logic [CMP_BITS-1:0] sample_plus_band;
	logic                is_dark;
	logic                is_light;
	logic [RUN_BITS-1:0] dark_nxt;
	logic [RUN_BITS-1:0] light_nxt;

	// light test as sample + band <= base, so a band above base never reads light
	assign sample_ext       = CMP_BITS'(item.sample);
	assign base_ext         = CMP_BITS'(cfg.base_level);
	assign hi_bound         = base_ext + CMP_BITS'(cfg.band);
	assign sample_plus_band = sample_ext + CMP_BITS'(cfg.band);
	assign is_dark          = (sample_ext >= hi_bound);
	assign is_light         = !is_dark && (sample_plus_band <= base_ext);

	always_comb begin
		dark_nxt  = '0;
		light_nxt = '0;
		if (is_dark) begin
			dark_nxt = (state_cur.dark_run < RUN_CAP) ? state_cur.dark_run + 1'b1
				: state_cur.dark_run;
		end
		if (is_light) begin
			light_nxt = (state_cur.light_run < RUN_CAP) ? state_cur.light_run + 1'b1
				: state_cur.light_run;
		end
	end

	always_comb begin
		state_nxt           = state_cur;
		result.zone         = ZONE_LIGHT;
		result.line_crossed = 1'b0;
		if (item.restart) begin
			state_nxt.dark_run  = '0;
			state_nxt.light_run = '0;
			state_nxt.crossing  = 1'b0;
			state_nxt.remaining = item.line_target;
		end else begin
			if (is_dark) begin
				result.zone = ZONE_DARK;
			end else if (is_light) begin
				result.zone = ZONE_LIGHT;
			end else begin
				result.zone = ZONE_UNCERTAIN;
			end
			state_nxt.dark_run  = dark_nxt;
			state_nxt.light_run = light_nxt;
			if ((dark_nxt >= cfg.settle_count) && !state_cur.crossing) begin
				state_nxt.crossing = 1'b1;
			end else if ((light_nxt >= cfg.settle_count) && state_cur.crossing) begin
				state_nxt.crossing  = 1'b0;
				result.line_crossed = 1'b1;
				if (state_cur.remaining != '0) begin
					state_nxt.remaining = state_cur.remaining - 1'b1;
				end
			end
		end
		result.lines_left = state_nxt.remaining;
		result.done_res   = (state_nxt.remaining == '0);
	end

endmodule

`default_nettype wire

// ----- src/hlcc_checker.sv -----
// port-level checks of the line-crossing counter, bound to the top level
// depends on hlcc_pkg and the assertion macro header
`default_nettype none
`include "hysteresis_line_crossing_counter_core_defines.svh"

module hlcc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [hlcc_pkg::LINE_BITS-1:0]   lines_left,
	input wire logic                             done_res
);
	import hlcc_pkg::*;

	// a held result stays offered until taken
	`HLCC_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// done flag tracks the line count
	`HLCC_CHECK(a_done_match, out_valid |-> (done_res == (lines_left == '0)), "done_res mismatch")

	// with the result stage empty the input side never stalls
	`HLCC_CHECK(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result pending")

	// an item taken while the result side is empty shows up on out_valid after passing the input and result registers
	`HLCC_CHECK(a_item_arrives, in_valid && in_ready && !out_valid |=> ##1 out_valid, "accepted item produced no result")

endmodule

bind hysteresis_line_crossing_counter_core hlcc_checker u_hlcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.lines_left (out_ch.lines_left),
	.done_res   (out_ch.done_res)
);

`default_nettype wire
